FILE: rtl/assert_macros.svh
// Assertion macros shared by the RTL.
// Define NO_ASSERTIONS to compile them away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
`define ASSERT_ALWAYS(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("assertion failed");
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication failed");
`else
`define ASSERT_ALWAYS(label, clk, rst, expr)
`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`endif

`endif

FILE: rtl/gcmp_pkg.sv
// Package for the grid controller message parser.
// Holds header codes, kinds, the message length table and shared types.
package gcmp_pkg;

  localparam int DEF_MAX_COLS     = 16;
  localparam int DEF_MAX_ROWS     = 16;
  localparam int DEF_MAX_ENCODERS = 4;

  localparam logic [7:0] FILL_BYTE   = 8'hFF;
  localparam logic [7:0] SUBSYS_RING = 8'h05;
  localparam logic [5:0] COUNT_MAX   = 6'd63;

  localparam logic [7:0] HDR_IDENTITY      = 8'h00;
  localparam logic [7:0] HDR_ID_STRING     = 8'h01;
  localparam logic [7:0] HDR_SYS_02        = 8'h02;
  localparam logic [7:0] HDR_GRID_SIZE     = 8'h03;
  localparam logic [7:0] HDR_SYS_04        = 8'h04;
  localparam logic [7:0] HDR_SYS_0F        = 8'h0F;
  localparam logic [7:0] HDR_KEY_UP        = 8'h20;
  localparam logic [7:0] HDR_KEY_DOWN      = 8'h21;
  localparam logic [7:0] HDR_RING_DELTA    = 8'h50;
  localparam logic [7:0] HDR_RING_KEY_UP   = 8'h51;
  localparam logic [7:0] HDR_RING_KEY_DOWN = 8'h52;
  localparam logic [7:0] HDR_TILT_80       = 8'h80;
  localparam logic [7:0] HDR_TILT_81       = 8'h81;

  localparam logic [1:0] EV_GRID_KEY   = 2'd0;
  localparam logic [1:0] EV_RING_KEY   = 2'd1;
  localparam logic [1:0] EV_RING_DELTA = 2'd2;

  localparam logic [1:0] DEV_UNKNOWN = 2'd0;
  localparam logic [1:0] DEV_GRID    = 2'd1;
  localparam logic [1:0] DEV_RING    = 2'd2;

  typedef struct packed {
    logic              event_valid;
    logic [1:0]        event_kind;
    logic [7:0]        key_x_or_encoder;
    logic [7:0]        key_y;
    logic              pressed;
    logic signed [7:0] turn_delta;
    logic [1:0]        unit_kind;
    logic [4:0]        grid_cols;
    logic [4:0]        grid_rows;
    logic [2:0]        encoder_count;
    logic              levels_supported;
  } gcmp_result_t;

  typedef struct packed {
    logic [5:0] frame_count;
    logic [5:0] frame_length;
    logic [7:0] header_byte;
    logic [7:0] payload_first;
    logic [7:0] payload_second;
    logic [1:0] kind_reg;
    logic [4:0] cols_reg;
    logic [4:0] rows_reg;
    logic [2:0] encoders_reg;
    logic       levels_reg;
  } gcmp_state_t;

  function automatic logic [5:0] msg_length(input logic [7:0] hdr);
    logic [5:0] len;
    case (hdr)
      HDR_IDENTITY:      len = 6'd3;
      HDR_ID_STRING:     len = 6'd33;
      HDR_SYS_02:        len = 6'd4;
      HDR_GRID_SIZE:     len = 6'd3;
      HDR_SYS_04:        len = 6'd3;
      HDR_SYS_0F:        len = 6'd9;
      HDR_KEY_UP:        len = 6'd3;
      HDR_KEY_DOWN:      len = 6'd3;
      HDR_RING_DELTA:    len = 6'd3;
      HDR_RING_KEY_UP:   len = 6'd2;
      HDR_RING_KEY_DOWN: len = 6'd2;
      HDR_TILT_80:       len = 6'd2;
      HDR_TILT_81:       len = 6'd8;
      default:           len = 6'd1;
    endcase
    return len;
  endfunction

endpackage

FILE: rtl/gcmp_core.sv
// Framing state and message decode for the message parser.
// Uses gcmp_pkg; updates state by one byte on each advance.
module gcmp_core import gcmp_pkg::*; #(
  parameter int MAX_COLS     = DEF_MAX_COLS,
  parameter int MAX_ROWS     = DEF_MAX_ROWS,
  parameter int MAX_ENCODERS = DEF_MAX_ENCODERS
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         advance,
  input  logic [7:0]   rx_byte,
  output gcmp_result_t result
);

  localparam int ENC_LIMIT = (MAX_ENCODERS > 7) ? 7 : MAX_ENCODERS;

  gcmp_state_t state;
  gcmp_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  always_comb begin
    logic [5:0] len;
    logic [5:0] cnt;
    logic [7:0] p1;
    logic [7:0] p2;
    state_next = state;
    result     = '0;
    len        = msg_length(rx_byte);
    p1         = (state.frame_count == 6'd1) ? rx_byte : state.payload_first;
    p2         = (state.frame_count == 6'd2) ? rx_byte : state.payload_second;
    cnt        = (state.frame_count < COUNT_MAX) ? state.frame_count + 6'd1
                                                 : state.frame_count;
    if (state.frame_length == 6'd0) begin
      if (rx_byte != FILL_BYTE) begin
        state_next.header_byte = rx_byte;
        if (len > 6'd1) begin
          state_next.frame_length = len;
          state_next.frame_count  = 6'd1;
        end else begin
          state_next.frame_count = 6'd0;
        end
      end
    end else begin
      state_next.payload_first  = p1;
      state_next.payload_second = p2;
      state_next.frame_count    = cnt;
      if (cnt >= state.frame_length) begin
        state_next.frame_length = 6'd0;
        state_next.frame_count  = 6'd0;
        case (state.header_byte)
          HDR_GRID_SIZE: begin
            if (p1 >= 8'd1 && p1 <= 8'(MAX_COLS) &&
                p2 >= 8'd1 && p2 <= 8'(MAX_ROWS)) begin
              state_next.kind_reg   = DEV_GRID;
              state_next.levels_reg = 1'b1;
              state_next.cols_reg   = p1[4:0];
              state_next.rows_reg   = p2[4:0];
            end
          end
          HDR_IDENTITY: begin
            if (p1 == SUBSYS_RING) begin
              state_next.kind_reg     = DEV_RING;
              state_next.levels_reg   = 1'b1;
              state_next.encoders_reg = (p2 > 8'(ENC_LIMIT)) ? 3'(ENC_LIMIT) : p2[2:0];
            end
          end
          HDR_KEY_UP, HDR_KEY_DOWN: begin
            result.event_valid      = 1'b1;
            result.pressed          = state.header_byte[0];
            result.key_x_or_encoder = p1;
            if (state.kind_reg == DEV_RING) begin
              result.event_kind = EV_RING_KEY;
            end else begin
              result.event_kind = EV_GRID_KEY;
              result.key_y      = p2;
            end
          end
          HDR_RING_DELTA: begin
            result.event_valid      = 1'b1;
            result.event_kind       = EV_RING_DELTA;
            result.key_x_or_encoder = p1;
            result.turn_delta       = p2;
          end
          HDR_RING_KEY_UP, HDR_RING_KEY_DOWN: begin
            result.event_valid      = 1'b1;
            result.event_kind       = EV_RING_KEY;
            result.key_x_or_encoder = p1;
            result.pressed          = (state.header_byte == HDR_RING_KEY_DOWN);
          end
          default: begin
          end
        endcase
      end
    end
    result.unit_kind        = state_next.kind_reg;
    result.grid_cols        = state_next.cols_reg;
    result.grid_rows        = state_next.rows_reg;
    result.encoder_count    = state_next.encoders_reg;
    result.levels_supported = state_next.levels_reg;
  end

endmodule

FILE: rtl/grid_controller_message_parser.sv
// Grid controller message parser: an accepted byte passes the input register, then the
// result register. Throughput one byte per cycle while the result is not stalled.
// The two registers part the channels, so a byte can be taken into an empty input
// register while a finished result waits. Synchronous active-high reset clears the framing
// state, the identity and both valid flags; the parser starts idle, device unknown.
`include "assert_macros.svh"

module grid_controller_message_parser import gcmp_pkg::*; #(
  parameter int MAX_COLS     = DEF_MAX_COLS,
  parameter int MAX_ROWS     = DEF_MAX_ROWS,
  parameter int MAX_ENCODERS = DEF_MAX_ENCODERS
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        rx_byte,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              event_valid,
  output logic [1:0]        event_kind,
  output logic [7:0]        key_x_or_encoder,
  output logic [7:0]        key_y,
  output logic              pressed,
  output logic signed [7:0] turn_delta,
  output logic [1:0]        unit_kind,
  output logic [4:0]        grid_cols,
  output logic [4:0]        grid_rows,
  output logic [2:0]        encoder_count,
  output logic              levels_supported
);

  localparam int ENC_LIMIT = (MAX_ENCODERS > 7) ? 7 : MAX_ENCODERS;

  logic         s1_valid;
  logic [7:0]   s1_byte;
  logic         advance;
  gcmp_result_t step_result;
  gcmp_result_t out_result;

  assign advance  = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_byte <= rx_byte;
    end
  end

  gcmp_core #(
    .MAX_COLS     (MAX_COLS),
    .MAX_ROWS     (MAX_ROWS),
    .MAX_ENCODERS (MAX_ENCODERS)
  ) u_core (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .rx_byte (s1_byte),
    .result  (step_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_result <= step_result;
    end
  end

  assign event_valid      = out_result.event_valid;
  assign event_kind       = out_result.event_kind;
  assign key_x_or_encoder = out_result.key_x_or_encoder;
  assign key_y            = out_result.key_y;
  assign pressed          = out_result.pressed;
  assign turn_delta       = out_result.turn_delta;
  assign unit_kind        = out_result.unit_kind;
  assign grid_cols        = out_result.grid_cols;
  assign grid_rows        = out_result.grid_rows;
  assign encoder_count    = out_result.encoder_count;
  assign levels_supported = out_result.levels_supported;

  `ASSERT_IMPLIES(a_no_event_fields, clk, rst, out_valid && !event_valid, event_kind == EV_GRID_KEY && key_x_or_encoder == 8'd0 && key_y == 8'd0 && !pressed && turn_delta == 8'sd0)
  `ASSERT_IMPLIES(a_delta_shape, clk, rst, out_valid && event_valid && event_kind == EV_RING_DELTA, key_y == 8'd0 && !pressed)
  `ASSERT_IMPLIES(a_enc_clamp, clk, rst, out_valid, encoder_count <= 3'(ENC_LIMIT))
  `ASSERT_IMPLIES(a_grid_range, clk, rst, out_valid, grid_cols <= 5'(MAX_COLS) && grid_rows <= 5'(MAX_ROWS))
  `ASSERT_IMPLIES(a_stall_source, clk, rst, in_stall, s1_valid && out_valid && out_stall)

endmodule
